### design/rhsl_pkg.sv
// ----------------------------------------------------------------------------
// rhsl_pkg: shared types and constants of the RGB to HSL converter
// Scale factors, divider lane layout and the sideband that rides along.
// ----------------------------------------------------------------------------
`default_nettype none

package rhsl_pkg;

    localparam int PIX_W     = 8;
    localparam int HSL_TOP   = 252;
    localparam int RGB_TOP   = 255;
    localparam int HUE_SIXTH = HSL_TOP / 6;
    localparam int HUE_THIRD = HSL_TOP / 3;
    localparam int HUE_GRAY  = HSL_TOP * 2 / 3;

    // Largest max+min for which lightness stays at or below HSL_TOP/2.
    localparam int SAT_SPLIT = 256;

    localparam int SUM_W = PIX_W + 1;
    localparam int NUM_W = 16;
    localparam int DEN_W = 9;
    localparam int QUO_W = 8;

    localparam int LANES    = 4;
    localparam int LANE_SAT = 0;
    localparam int LANE_RED = 1;
    localparam int LANE_GRN = 2;
    localparam int LANE_BLU = 3;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    // One restoring-division lane: partial remainder, divisor, quotient so far.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } lane_t;

    // Per-pixel data that travels beside the divider lanes.
    typedef struct packed {
        logic             gray;
        chan_t            sel;
        logic             last;
        logic [NUM_W-1:0] light_x;
        logic [PIX_W-1:0] light_q0;
    } side_t;

endpackage

`default_nettype wire

### design/rgb_to_hsl_pixel_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_converter: streaming RGB to HSL pixel converter
// Integer hue, saturation and lightness on a 0..252 scale, one pixel a clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one 8-bit RGB pixel per transaction and returns its hue, saturation
// and lightness, each scaled to 0..252 with rounded integer divisions. A gray
// pixel gives saturation 0 and hue 168. The line-end flag rides along on
// tlast. The block accepts one pixel every clock while s_tready is high; a
// result passes through 4 front stages (max/min, sums, products,
// dividends), 8 stages of the restoring divider that yields one quotient bit
// per stage in all four lanes (saturation and three hue deltas), and the
// output register. The whole pipeline moves whenever the output register is
// empty or being drained, so s_tready drops only while a result sits on
// m_tdata and the sink holds m_tready low. No reset-time clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_pixel_converter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // slave side: pixels
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,    // red [7:0], green [15:8], blue [23:16]
    input  wire logic        s_tlast,    // line_end
    // master side: HSL results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // hue [7:0], saturation [15:8], lightness [23:16]
    output logic             m_tlast     // line_end_out
);
    import rhsl_pkg::*;

    logic              adv;
    logic              f_valid, d_valid;
    lane_t [LANES-1:0] f_lanes, d_lanes;
    side_t             f_side, d_side;
    logic [PIX_W-1:0]  hue, saturation, lightness;

    // Single advance for every stage: move when the output slot frees up.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    rhsl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .line_end  (s_tlast),
        .out_valid (f_valid),
        .out_lanes (f_lanes),
        .out_side  (f_side)
    );

    rhsl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_lanes  (f_lanes),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_lanes (d_lanes),
        .out_side  (d_side)
    );

    rhsl_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (d_valid),
        .in_lanes     (d_lanes),
        .in_side      (d_side),
        .out_valid    (m_tvalid),
        .hue          (hue),
        .saturation   (saturation),
        .lightness    (lightness),
        .line_end_out (m_tlast)
    );

    assign m_tdata = {lightness, saturation, hue};

    // Saturation is zero only for gray pixels, and those carry the gray hue.
    a_gray_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[15:8] == 8'd0) |-> (m_tdata[7:0] == 8'(HUE_GRAY)))
        else $error("zero saturation without gray hue");

    // All three components stay on the 0..252 scale.
    a_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] <= 8'(HSL_TOP)) && (m_tdata[15:8] <= 8'(HSL_TOP))
                     && (m_tdata[23:16] <= 8'(HSL_TOP)))
        else $error("HSL component above scale");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

### design/rhsl_front.sv
// ----------------------------------------------------------------------------
// rhsl_front: max/min, sums and dividend setup
// Four register stages that turn a pixel into divider lanes and sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module rhsl_front (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   adv,
    input  wire logic                                   in_valid,
    input  wire logic [rhsl_pkg::PIX_W-1:0]             red,
    input  wire logic [rhsl_pkg::PIX_W-1:0]             green,
    input  wire logic [rhsl_pkg::PIX_W-1:0]             blue,
    input  wire logic                                   line_end,
    output logic                                        out_valid,
    output rhsl_pkg::lane_t [rhsl_pkg::LANES-1:0]       out_lanes,
    output rhsl_pkg::side_t                             out_side
);
    import rhsl_pkg::*;

    // stage 1: channels, extremes, winning channel
    logic [PIX_W-1:0] r1_reg, g1_reg, b1_reg, max1_reg, min1_reg;
    chan_t            sel1_reg;
    logic             last1_reg, v1_reg;
    logic [PIX_W-1:0] max1_next, min1_next;
    chan_t            sel1_next;

    always_comb begin
        if (red >= green && red >= blue) begin
            max1_next = red;
            sel1_next = CH_RED;
        end else if (green >= blue) begin
            max1_next = green;
            sel1_next = CH_GREEN;
        end else begin
            max1_next = blue;
            sel1_next = CH_BLUE;
        end
        min1_next = red;
        if (green < min1_next) min1_next = green;
        if (blue < min1_next) min1_next = blue;
    end

    // stage 2: sum, range, per-channel distance from max
    logic [SUM_W-1:0] sum2_reg;
    logic [PIX_W-1:0] range2_reg, dr2_reg, dg2_reg, db2_reg;
    logic             gray2_reg, last2_reg, v2_reg;
    chan_t            sel2_reg;

    // stage 3: products
    logic [DEN_W-1:0] den3_reg, den3_next;
    logic [NUM_W-1:0] satp3_reg, dnr3_reg, dng3_reg, dnb3_reg, lx3_reg;
    logic [PIX_W-1:0] range3_reg;
    logic             gray3_reg, last3_reg, v3_reg;
    chan_t            sel3_reg;

    always_comb begin
        if (sum2_reg <= SUM_W'(SAT_SPLIT)) begin
            den3_next = DEN_W'(sum2_reg);
        end else begin
            den3_next = DEN_W'(2 * RGB_TOP) - DEN_W'(sum2_reg);
        end
    end

    // stage 4: final dividends, first lightness estimate (x * 257 >> 16 ~ x / 255)
    logic                      v4_reg;
    lane_t [LANES-1:0]         lanes4_reg, lanes4_next;
    side_t                     side4_reg, side4_next;
    logic [NUM_W+PIX_W-1:0]    lx_mul;

    always_comb begin
        lx_mul = {{PIX_W{1'b0}}, lx3_reg} + {lx3_reg, {PIX_W{1'b0}}};
        lanes4_next[LANE_SAT].rem = satp3_reg + NUM_W'(den3_reg >> 1);
        lanes4_next[LANE_SAT].den = den3_reg;
        lanes4_next[LANE_SAT].quo = '0;
        lanes4_next[LANE_RED].rem = dnr3_reg;
        lanes4_next[LANE_GRN].rem = dng3_reg;
        lanes4_next[LANE_BLU].rem = dnb3_reg;
        for (int j = LANE_RED; j <= LANE_BLU; j++) begin
            lanes4_next[j].den = DEN_W'(range3_reg);
            lanes4_next[j].quo = '0;
        end
        side4_next.gray     = gray3_reg;
        side4_next.sel      = sel3_reg;
        side4_next.last     = last3_reg;
        side4_next.light_x  = lx3_reg;
        side4_next.light_q0 = lx_mul[NUM_W+PIX_W-1:NUM_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_reg    <= red;
            g1_reg    <= green;
            b1_reg    <= blue;
            max1_reg  <= max1_next;
            min1_reg  <= min1_next;
            sel1_reg  <= sel1_next;
            last1_reg <= line_end;

            sum2_reg   <= {1'b0, max1_reg} + {1'b0, min1_reg};
            range2_reg <= max1_reg - min1_reg;
            dr2_reg    <= max1_reg - r1_reg;
            dg2_reg    <= max1_reg - g1_reg;
            db2_reg    <= max1_reg - b1_reg;
            gray2_reg  <= (max1_reg == min1_reg);
            sel2_reg   <= sel1_reg;
            last2_reg  <= last1_reg;

            den3_reg   <= den3_next;
            satp3_reg  <= {{(NUM_W-PIX_W){1'b0}}, range2_reg} * NUM_W'(HSL_TOP);
            dnr3_reg   <= {{(NUM_W-PIX_W){1'b0}}, dr2_reg} * NUM_W'(HUE_SIXTH)
                          + NUM_W'(range2_reg >> 1);
            dng3_reg   <= {{(NUM_W-PIX_W){1'b0}}, dg2_reg} * NUM_W'(HUE_SIXTH)
                          + NUM_W'(range2_reg >> 1);
            dnb3_reg   <= {{(NUM_W-PIX_W){1'b0}}, db2_reg} * NUM_W'(HUE_SIXTH)
                          + NUM_W'(range2_reg >> 1);
            lx3_reg    <= {{(NUM_W-SUM_W){1'b0}}, sum2_reg} * NUM_W'(HSL_TOP / 2)
                          + NUM_W'(RGB_TOP / 2);
            range3_reg <= range2_reg;
            gray3_reg  <= gray2_reg;
            sel3_reg   <= sel2_reg;
            last3_reg  <= last2_reg;

            lanes4_reg <= lanes4_next;
            side4_reg  <= side4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_lanes = lanes4_reg;
    assign out_side  = side4_reg;

endmodule

`default_nettype wire

### design/rhsl_div.sv
// ----------------------------------------------------------------------------
// rhsl_div: pipelined restoring divider, four lanes
// One quotient bit per stage, QUO_W stages, sideband carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rhsl_div (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   adv,
    input  wire logic                                   in_valid,
    input  wire rhsl_pkg::lane_t [rhsl_pkg::LANES-1:0]  in_lanes,
    input  wire rhsl_pkg::side_t                        in_side,
    output logic                                        out_valid,
    output rhsl_pkg::lane_t [rhsl_pkg::LANES-1:0]       out_lanes,
    output rhsl_pkg::side_t                             out_side
);
    import rhsl_pkg::*;

    localparam int EXT_W = NUM_W + 1;

    // Try to take den << bpos out of the remainder; dividend < den << QUO_W.
    function automatic lane_t div_step(input lane_t cur, input int unsigned bpos);
        logic [EXT_W-1:0] trial;
        lane_t            nxt;
        trial = EXT_W'(cur.den) << bpos;
        nxt   = cur;
        if (EXT_W'(cur.rem) >= trial) begin
            nxt.rem = cur.rem - NUM_W'(trial);
            nxt.quo = cur.quo | (QUO_W'(1) << bpos);
        end
        return nxt;
    endfunction

    lane_t [LANES-1:0] lane_reg [QUO_W];
    side_t             side_reg [QUO_W];
    logic [QUO_W-1:0]  valid_reg;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        lane_t [LANES-1:0] stage_in, stage_next;
        side_t             side_in;
        logic              v_in;

        if (k == 0) begin : g_first
            assign stage_in = in_lanes;
            assign side_in  = in_side;
            assign v_in     = in_valid;
        end else begin : g_next
            assign stage_in = lane_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign v_in     = valid_reg[k-1];
        end

        always_comb begin
            for (int j = 0; j < LANES; j++) begin
                stage_next[j] = div_step(stage_in[j], QUO_W - 1 - k);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                lane_reg[k] <= stage_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_lanes = lane_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

`default_nettype wire

### design/rhsl_back.sv
// ----------------------------------------------------------------------------
// rhsl_back: hue assembly, lightness fixup, output register
// Combines the quotients into H, S, L and holds the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rhsl_back (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   adv,
    input  wire logic                                   in_valid,
    input  wire rhsl_pkg::lane_t [rhsl_pkg::LANES-1:0]  in_lanes,
    input  wire rhsl_pkg::side_t                        in_side,
    output logic                                        out_valid,
    output logic [rhsl_pkg::PIX_W-1:0]                  hue,
    output logic [rhsl_pkg::PIX_W-1:0]                  saturation,
    output logic [rhsl_pkg::PIX_W-1:0]                  lightness,
    output logic                                        line_end_out
);
    import rhsl_pkg::*;

    localparam int HT_W = PIX_W + 2;

    logic [NUM_W-1:0] q0_x255, light_rem;
    logic [PIX_W-1:0] light_next, hue_next, sat_next;
    logic [PIX_W-1:0] rd, gd, bd;
    logic [HT_W-1:0]  hue_t;

    logic             valid_reg, last_reg;
    logic [PIX_W-1:0] hue_reg, sat_reg, light_reg;

    always_comb begin
        // estimate is exact or one low: fix with the remainder
        q0_x255    = {in_side.light_q0, {PIX_W{1'b0}}}
                     - {{(NUM_W-PIX_W){1'b0}}, in_side.light_q0};
        light_rem  = in_side.light_x - q0_x255;
        light_next = in_side.light_q0
                     + PIX_W'(light_rem >= NUM_W'(RGB_TOP));

        rd = in_lanes[LANE_RED].quo;
        gd = in_lanes[LANE_GRN].quo;
        bd = in_lanes[LANE_BLU].quo;

        // hue offset by HSL_TOP so the sum never goes negative
        case (in_side.sel)
            CH_RED:   hue_t = HT_W'(HSL_TOP) + HT_W'(bd) - HT_W'(gd);
            CH_GREEN: hue_t = HT_W'(HSL_TOP + HUE_THIRD) + HT_W'(rd) - HT_W'(bd);
            CH_BLUE:  hue_t = HT_W'(HSL_TOP + HUE_GRAY) + HT_W'(gd) - HT_W'(rd);
            default:  hue_t = HT_W'(HSL_TOP);
        endcase

        if (hue_t < HT_W'(HSL_TOP)) begin
            hue_next = PIX_W'(hue_t);
        end else if (hue_t > HT_W'(2 * HSL_TOP)) begin
            hue_next = PIX_W'(hue_t - HT_W'(2 * HSL_TOP));
        end else begin
            hue_next = PIX_W'(hue_t - HT_W'(HSL_TOP));
        end
        sat_next = in_lanes[LANE_SAT].quo;

        if (in_side.gray) begin
            hue_next = PIX_W'(HUE_GRAY);
            sat_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            light_reg <= light_next;
            last_reg  <= in_side.last;
        end
    end

    assign out_valid    = valid_reg;
    assign hue          = hue_reg;
    assign saturation   = sat_reg;
    assign lightness    = light_reg;
    assign line_end_out = last_reg;

endmodule

`default_nettype wire
